[hdl/u8seg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8seg_pkg
// Shared types, constants and decode helpers for the UTF-8 sentence segmenter.
// ----------------------------------------------------------------------------
package u8seg_pkg;

	localparam logic [7:0] LIMIT_MAX   = 8'd240;
	localparam logic [7:0] LIMIT_MIN   = 8'd8;
	localparam logic [7:0] LIMIT_RESET = 8'd240;

	// UTF-8 lead byte classes
	localparam logic [7:0] LEAD2_MASK = 8'he0;
	localparam logic [7:0] LEAD2_CODE = 8'hc0;
	localparam logic [7:0] LEAD3_MASK = 8'hf0;
	localparam logic [7:0] LEAD3_CODE = 8'he0;
	localparam logic [7:0] LEAD4_MASK = 8'hf8;
	localparam logic [7:0] LEAD4_CODE = 8'hf0;

	// CJK and fullwidth punctuation marks
	localparam logic [7:0] CJK_LEAD = 8'he3;
	localparam logic [7:0] CJK_MID  = 8'h80;
	localparam logic [7:0] FW_LEAD  = 8'hef;
	localparam logic [7:0] FW_MID   = 8'hbc;

	// Configuration register indexes
	localparam logic [0:0] REG_SEGMENT_LIMIT = 1'b0;

	typedef enum logic [1:0] {
		MARK_NONE = 2'd0,
		MARK_CJK  = 2'd1,
		MARK_FW   = 2'd2
	} mark_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} text_beat_t;

	typedef struct packed {
		logic [7:0] segment_length;
		logic       cut_at_break;
		logic       final_segment;
		logic       last_of_run;
	} seg_beat_t;

	typedef struct packed {
		logic [7:0] window_count;
		logic [7:0] last_break_end;
		logic [7:0] fit_boundary;
		logic [1:0] char_bytes_left;
		mark_t      mark_prefix;
	} text_state_t;

	function automatic logic is_ascii_break(input logic [7:0] b);
		return (b == 8'h0a) || (b == 8'h2e) || (b == 8'h21) ||
		       (b == 8'h3f) || (b == 8'h3b) || (b == 8'h3a);
	endfunction

	function automatic logic is_cjk_tail(input logic [7:0] b);
		return (b == 8'h80) || (b == 8'h81) || (b == 8'h82) || (b == 8'h84);
	endfunction

	function automatic logic is_fw_tail(input logic [7:0] b);
		return (b == 8'h81) || (b == 8'h8c) || (b == 8'h9b) || (b == 8'h9f);
	endfunction

	// Number of continuation bytes that follow a lead byte
	function automatic logic [1:0] cont_count(input logic [7:0] b);
		if ((b & LEAD2_MASK) == LEAD2_CODE) return 2'd1;
		else if ((b & LEAD3_MASK) == LEAD3_CODE) return 2'd2;
		else if ((b & LEAD4_MASK) == LEAD4_CODE) return 2'd3;
		else return 2'd0;
	endfunction

endpackage

[hdl/utf8_sentence_segmenter_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_sentence_segmenter_core
// Cuts a UTF-8 byte stream into segments no longer than the configured limit,
// preferring to end on a sentence break.
// ----------------------------------------------------------------------------
// One text byte is taken per cycle unless in_stall is high. A byte sits in the
// input register, where the cut/decode logic runs, and its results land in a
// four-entry result queue that drives the output channel. A byte yields zero,
// one or two segment beats, and the output channel moves one beat per cycle
// while out_stall is low, so the input stalls only while the queue has fewer
// than two free slots (bytes that give both a limit cut and the final segment,
// or a stalled output). segment_limit is clamped to 8..240 and is to be
// written only while no text is in flight.
module utf8_sentence_segmenter_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  u8seg_pkg::text_beat_t in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output u8seg_pkg::seg_beat_t  out_data,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	u8seg_pkg::text_beat_t  beat_s1;
	logic                   valid_s1;
	u8seg_pkg::text_state_t state_q;
	u8seg_pkg::text_state_t state_next;
	u8seg_pkg::seg_beat_t   res0;
	u8seg_pkg::seg_beat_t   res1;
	logic [1:0]             res_count;
	logic [1:0]             push_count;
	logic [7:0]             limit;
	logic                   room2;
	logic                   advance;
	logic                   accept;

	u8seg_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.limit   (limit)
	);

	assign advance  = valid_s1 && room2;
	assign in_stall = valid_s1 && !room2;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) beat_s1 <= in_data;
	end

	u8seg_step u_step (
		.st        (state_q),
		.beat      (beat_s1),
		.limit     (limit),
		.st_next   (state_next),
		.res0      (res0),
		.res1      (res1),
		.res_count (res_count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	assign push_count = advance ? res_count : 2'd0;

	u8seg_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_count (push_count),
		.push0      (res0),
		.push1      (res1),
		.room2      (room2),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

	a_final_closes_run: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && beat_s1.end_of_text) |=> (state_q.window_count == 8'd0))
		else $error("text state not cleared after final segment");

	a_final_not_break: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.final_segment) |->
		(out_data.last_of_run && !out_data.cut_at_break))
		else $error("final segment beat flags inconsistent");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_data)))
		else $error("stalled segment beat changed");

endmodule

[hdl/u8seg_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8seg_cfg
// APB register slave holding the segment limit; also presents the clamped
// working limit.
// ----------------------------------------------------------------------------
module u8seg_cfg (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [7:0]  limit
);

	logic [7:0] segment_limit_q;
	logic       reg_hit;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[2] == u8seg_pkg::REG_SEGMENT_LIMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			segment_limit_q <= u8seg_pkg::LIMIT_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			segment_limit_q <= pwdata[7:0];
		end
	end

	assign prdata = reg_hit ? {24'd0, segment_limit_q} : 32'd0;

	// clamp to the legal working range
	always_comb begin
		if (segment_limit_q < u8seg_pkg::LIMIT_MIN) begin
			limit = u8seg_pkg::LIMIT_MIN;
		end else if (segment_limit_q > u8seg_pkg::LIMIT_MAX) begin
			limit = u8seg_pkg::LIMIT_MAX;
		end else begin
			limit = segment_limit_q;
		end
	end

endmodule

[hdl/u8seg_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8seg_step
// Per-byte segmentation logic: limit cut, character decode, break tracking
// and end-of-text flush. Produces the next text state and up to two results.
// ----------------------------------------------------------------------------
module u8seg_step (
	input  u8seg_pkg::text_state_t st,
	input  u8seg_pkg::text_beat_t  beat,
	input  logic [7:0]             limit,
	output u8seg_pkg::text_state_t st_next,
	output u8seg_pkg::seg_beat_t   res0,
	output u8seg_pkg::seg_beat_t   res1,
	output logic [1:0]             res_count
);

	logic [6:0]             half;
	logic                   cut;
	logic                   cut_brk;
	logic [7:0]             cut_len;
	u8seg_pkg::text_state_t mid;
	u8seg_pkg::text_state_t nxt;
	logic                   done;
	logic                   brk;
	logic [1:0]             n_cont;
	logic [7:0]             b;
	u8seg_pkg::seg_beat_t   cut_res;
	u8seg_pkg::seg_beat_t   fin_res;

	assign b    = beat.text_byte;
	assign half = limit[7:1];

	// Limit cut before the new byte goes in
	always_comb begin
		cut     = (st.window_count >= limit);
		cut_brk = (st.last_break_end != 8'd0) && (st.last_break_end >= {1'b0, half});
		cut_len = cut_brk ? st.last_break_end : st.fit_boundary;
		mid     = st;
		if (cut) begin
			mid.window_count   = st.window_count - cut_len;
			mid.fit_boundary   = st.fit_boundary - cut_len;
			mid.last_break_end = 8'd0;
		end
	end

	// Take the byte
	always_comb begin
		nxt              = mid;
		nxt.window_count = mid.window_count + 8'd1;
		done             = 1'b0;
		brk              = 1'b0;
		n_cont           = u8seg_pkg::cont_count(b);
		case (mid.char_bytes_left)
			2'd0: begin
				if (n_cont == 2'd0) begin
					done = 1'b1;
					brk  = u8seg_pkg::is_ascii_break(b);
				end else begin
					nxt.char_bytes_left = n_cont;
					if (b == u8seg_pkg::CJK_LEAD) nxt.mark_prefix = u8seg_pkg::MARK_CJK;
					else if (b == u8seg_pkg::FW_LEAD) nxt.mark_prefix = u8seg_pkg::MARK_FW;
					else nxt.mark_prefix = u8seg_pkg::MARK_NONE;
				end
			end
			2'd2: begin
				if ((mid.mark_prefix == u8seg_pkg::MARK_CJK && b != u8seg_pkg::CJK_MID) ||
				    (mid.mark_prefix == u8seg_pkg::MARK_FW && b != u8seg_pkg::FW_MID)) begin
					nxt.mark_prefix = u8seg_pkg::MARK_NONE;
				end
				nxt.char_bytes_left = 2'd1;
			end
			2'd1: begin
				if (mid.mark_prefix == u8seg_pkg::MARK_CJK) brk = u8seg_pkg::is_cjk_tail(b);
				else if (mid.mark_prefix == u8seg_pkg::MARK_FW) brk = u8seg_pkg::is_fw_tail(b);
				nxt.char_bytes_left = 2'd0;
				done                = 1'b1;
			end
			default: begin
				nxt.char_bytes_left = 2'd2;
				nxt.mark_prefix     = u8seg_pkg::MARK_NONE;
			end
		endcase
		if (done) begin
			nxt.mark_prefix  = u8seg_pkg::MARK_NONE;
			nxt.fit_boundary = nxt.window_count;
			if (brk) nxt.last_break_end = nxt.window_count;
		end
	end

	// Results and flush
	always_comb begin
		cut_res.segment_length = cut_len;
		cut_res.cut_at_break   = cut_brk;
		cut_res.final_segment  = 1'b0;
		cut_res.last_of_run    = !beat.end_of_text;

		fin_res.segment_length = nxt.window_count;
		fin_res.cut_at_break   = 1'b0;
		fin_res.final_segment  = 1'b1;
		fin_res.last_of_run    = 1'b1;

		st_next = nxt;
		if (beat.end_of_text) st_next = '0;

		res0 = cut ? cut_res : fin_res;
		res1 = fin_res;
		res_count = {1'b0, cut} + {1'b0, beat.end_of_text};
	end

endmodule

[hdl/u8seg_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8seg_fifo
// Four-entry result queue; takes up to two results per cycle and presents
// one beat per cycle on the output channel while out_stall is low.
// ----------------------------------------------------------------------------
module u8seg_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [1:0]           push_count,
	input  u8seg_pkg::seg_beat_t push0,
	input  u8seg_pkg::seg_beat_t push1,
	output logic                 room2,
	output logic                 out_valid,
	input  logic                 out_stall,
	output u8seg_pkg::seg_beat_t out_data
);

	u8seg_pkg::seg_beat_t entry_q [4];
	logic [1:0]           wr_ptr_q;
	logic [1:0]           rd_ptr_q;
	logic [2:0]           count_q;
	logic                 pop;

	assign out_valid = (count_q != 3'd0);
	assign out_data  = entry_q[rd_ptr_q];
	assign pop       = out_valid && !out_stall;
	assign room2     = (count_q <= 3'd2);

	always_ff @(posedge clk) begin
		if (push_count != 2'd0) entry_q[wr_ptr_q] <= push0;
		if (push_count == 2'd2) entry_q[wr_ptr_q + 2'd1] <= push1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			count_q  <= 3'd0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push_count;
			if (pop) rd_ptr_q <= rd_ptr_q + 2'd1;
			count_q <= count_q + {1'b0, push_count} - {2'd0, pop};
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 3'd4)
		else $error("result queue count out of range");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, count_q} + {2'd0, push_count}) <= 4'd4)
		else $error("result queue overflow");

	a_pop_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && push_count == 2'd0) |=> (count_q == $past(count_q) - 3'd1))
		else $error("result queue count did not drop on pop");

endmodule
